### rtl/rta_pkg.sv
// ----------------------------------------------------------------------------
// Round-trip-time window average tracker: shared definitions
// Widths, window depth and the types that pass between the modules.
// ----------------------------------------------------------------------------
package rta_pkg;

   localparam int WINDOW_DEPTH = 16;

   localparam int SAMPLE_W = 24;
   localparam int GRAD_W   = SAMPLE_W + 1;
   localparam int HELD_W   = 5;
   localparam int LOG_W    = $clog2(WINDOW_DEPTH);
   localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W    = SAMPLE_W + LOG_W;
   localparam int STEP_W   = $clog2(SAMPLE_W + 1);
   localparam int EMA_W    = SAMPLE_W + 3;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [CNT_W-1:0]    count_type;

   typedef struct packed {
      logic       start;
      sum_type    dividend;
      count_type  divisor;
   } div_request_type;

   typedef struct packed {
      logic       busy;
      sample_type quotient;
   } div_status_type;

endpackage

### rtl/rta_req_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Carries one round-trip-time sample per item under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rta_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [rta_pkg::GRAD_W-1:0] rtt_sample;

   modport source (output valid, output rtt_sample, input ready);
   modport sink (input valid, input rtt_sample, output ready);
endinterface

### rtl/rta_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries gradient, window average, smoothed average and fill per item.
// ----------------------------------------------------------------------------
interface rta_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rta_pkg::GRAD_W-1:0] rtt_gradient;
   logic [rta_pkg::SAMPLE_W-1:0]      window_average;
   logic [rta_pkg::SAMPLE_W-1:0]      smoothed_average;
   logic [rta_pkg::HELD_W-1:0]        samples_held;

   modport source (output valid, output rtt_gradient, output window_average,
                   output smoothed_average, output samples_held, input ready);
   modport sink (input valid, input rtt_gradient, input window_average,
                 input smoothed_average, input samples_held, output ready);
endinterface

### rtl/rta_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one sample of the window and passes it on to the next cell on a shift.
// ----------------------------------------------------------------------------
module rta_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  rta_pkg::sample_type sample_in,
   output rta_pkg::sample_type sample_out
);

   rta_pkg::sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

### rtl/rta_divider.sv
// ----------------------------------------------------------------------------
// Window average divider
// Restoring divider that gives one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rta_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  rta_pkg::div_request_type request,
   output rta_pkg::div_status_type  status
);

   logic                            busy_ff, busy_in;
   logic [rta_pkg::STEP_W-1:0]      step_ff, step_in;
   rta_pkg::count_type              rem_ff, rem_in;
   rta_pkg::sample_type             quo_ff, quo_in;
   rta_pkg::count_type              divisor_ff, divisor_in;
   logic [rta_pkg::CNT_W:0]         partial;
   logic [rta_pkg::CNT_W+1:0]       diff;

   always_comb begin
      partial    = {rem_ff, quo_ff[rta_pkg::SAMPLE_W-1]};
      diff       = {1'b0, partial} - {2'b00, divisor_ff};
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (request.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = rta_pkg::CNT_W'(request.dividend[rta_pkg::SUM_W-1:rta_pkg::SAMPLE_W]);
         quo_in     = request.dividend[rta_pkg::SAMPLE_W-1:0];
         divisor_in = request.divisor;
      end else if (busy_ff) begin
         if (!diff[rta_pkg::CNT_W+1]) begin
            rem_in = diff[rta_pkg::CNT_W-1:0];
         end else begin
            rem_in = partial[rta_pkg::CNT_W-1:0];
         end
         quo_in  = {quo_ff[rta_pkg::SAMPLE_W-2:0], ~diff[rta_pkg::CNT_W+1]};
         step_in = step_ff + 1'b1;
         if (step_ff == rta_pkg::STEP_W'(rta_pkg::SAMPLE_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy     = busy_ff;
   assign status.quotient = quo_ff;

endmodule

### rtl/rtt_window_average_tracker.sv
// ----------------------------------------------------------------------------
// Round-trip-time window average tracker
// Sliding-window mean over the last samples held in a row of cells, plus an
// exponential average and the gradient against the previous sample.
// ----------------------------------------------------------------------------
//  Channel   Direction  Item
//  req_chan  in         rtt_sample (signed; zero or below is dropped)
//  rsp_chan  out        rtt_gradient, window_average, smoothed_average,
//                       samples_held
//
//  A positive sample's result is registered once the bit-serial divider
//  (one quotient bit per cycle) is done. A dropped sample gives no result
//  and leaves the block ready. Reset clears the window cells, the sum, the
//  fill count and the smoothed average. A stalled result is held in the
//  output register while the next sample is already taken in and worked on.
// ----------------------------------------------------------------------------
module rtt_window_average_tracker (
   input  logic       clock,
   input  logic       reset,
   rta_req_if.sink    req_chan,
   rta_rsp_if.source  rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;

   logic [1:0]                 state_ff, state_in;
   rta_pkg::sum_type           sum_ff, sum_in;
   rta_pkg::count_type         count_ff, count_in;
   rta_pkg::sample_type        ema_ff, ema_in;
   logic [rta_pkg::GRAD_W-1:0] grad_ff, grad_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rta_pkg::GRAD_W-1:0] out_grad_ff;
   rta_pkg::sample_type        out_avg_ff;
   rta_pkg::sample_type        out_ema_ff;
   rta_pkg::count_type         out_count_ff;

   logic                       accept;
   logic                       positive;
   logic                       shift_en;
   logic                       load_out;
   rta_pkg::sample_type        rtt;
   logic [rta_pkg::EMA_W-1:0]  ema_times7;
   rta_pkg::sample_type        chain [rta_pkg::WINDOW_DEPTH+1];
   rta_pkg::div_request_type   div_request;
   rta_pkg::div_status_type    div_status;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rtt      = req_chan.rtt_sample[rta_pkg::SAMPLE_W-1:0];
   assign positive = !req_chan.rtt_sample[rta_pkg::GRAD_W-1] && (rtt != '0);
   assign shift_en = accept && positive;
   assign chain[0] = rtt;

   for (genvar i = 0; i < rta_pkg::WINDOW_DEPTH; i++) begin : g_cell
      rta_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .sample_in  (chain[i]),
         .sample_out (chain[i+1])
      );
   end

   assign div_request.start    = (state_ff == ST_START);
   assign div_request.dividend = sum_ff;
   assign div_request.divisor  = count_ff;

   rta_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .request (div_request),
      .status  (div_status)
   );

   assign load_out = (state_ff == ST_DIV) && !div_status.busy
                     && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      ema_times7   = (rta_pkg::EMA_W'(ema_ff) << 3) - rta_pkg::EMA_W'(ema_ff);
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ema_in       = ema_ff;
      grad_in      = grad_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (shift_en) begin
               sum_in  = sum_ff + rta_pkg::SUM_W'(rtt)
                         - rta_pkg::SUM_W'(chain[rta_pkg::WINDOW_DEPTH]);
               grad_in = {1'b0, rtt} - {1'b0, chain[1]};
               ema_in  = ema_times7[rta_pkg::EMA_W-1:3] + (rtt >> 3);
               if (count_ff < rta_pkg::CNT_W'(rta_pkg::WINDOW_DEPTH)) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ema_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ema_ff       <= ema_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grad_ff <= grad_in;
      if (load_out) begin
         out_grad_ff  <= grad_ff;
         out_avg_ff   <= div_status.quotient;
         out_ema_ff   <= ema_ff;
         out_count_ff <= count_ff;
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.rtt_gradient     = $signed(out_grad_ff);
   assign rsp_chan.window_average   = out_avg_ff;
   assign rsp_chan.smoothed_average = out_ema_ff;
   assign rsp_chan.samples_held     = rta_pkg::HELD_W'(out_count_ff);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the round-trip-time window average tracker
// Samples are sent from a queue, a directed part first and then random
// traffic. Each accepted positive sample is tracked by a predictor of the
// window, the gradient and the exponential average, and every result item is
// checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
   import rta_pkg::*;

   localparam int RANDOM_SAMPLES = 1200;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int IDLE_PERCENT   = 31;
   localparam int CALM_FROM      = 8000;
   localparam int CALM_TO        = 14000;
   localparam int HOLD_START     = 3000;
   localparam int HOLD_CYCLES    = 500;
   localparam int SETTLE_CYCLES  = 60;

   typedef struct packed {
      logic signed [GRAD_W-1:0] rtt_sample;
      logic                     drain_first;
   } sample_item_t;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gradient;
      sample_type               window_avg;
      sample_type               smoothed;
      logic [HELD_W-1:0]        held;
   } rtt_stats_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rta_req_if req_chan ();
   rta_rsp_if rsp_chan ();

   rtt_window_average_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   sample_item_t sample_queue[$];
   rtt_stats_t   rtt_stats_expected[$];
   sample_item_t next_item;
   rtt_stats_t   want;

   sample_type        ring_copy [WINDOW_DEPTH];
   longint unsigned   sum_copy;
   longint unsigned   ema_copy;
   int                fill_copy;
   int                newest_copy;
   int                oldest_copy;

   int cycle_count     = 0;
   int monitor_cycles  = 0;
   int hold_left       = 0;
   int samples_total   = 0;
   int samples_sent    = 0;
   int samples_dropped = 0;
   int results_checked = 0;
   int window_wraps    = 0;
   int fail_count      = 0;

   function automatic bit calm_window();
      return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
   endfunction

   function automatic void clear_window_copy();
      foreach (ring_copy[i]) ring_copy[i] = '0;
      sum_copy    = 0;
      ema_copy    = 0;
      fill_copy   = 0;
      newest_copy = 0;
      oldest_copy = 0;
   endfunction

   // Updates the window copy with one accepted sample and queues its result.
   function automatic void track_rtt_sample(input logic signed [GRAD_W-1:0] sample);
      sample_type        rtt;
      logic [GRAD_W-1:0] diff;
      longint unsigned   rtt_wide;
      rtt_stats_t        stats;
      if (sample <= 0) begin
         samples_dropped++;
         return;
      end
      rtt      = sample[SAMPLE_W-1:0];
      rtt_wide = rtt;
      sum_copy += rtt_wide;
      diff     = {1'b0, rtt} - {1'b0, ring_copy[newest_copy]};
      ema_copy = (ema_copy * 875) / 1000 + (rtt_wide * 125) / 1000;
      ema_copy = ema_copy & 64'hFF_FFFF;
      if (fill_copy > 0) newest_copy = (newest_copy + 1) % WINDOW_DEPTH;
      if (fill_copy < WINDOW_DEPTH) begin
         ring_copy[newest_copy] = rtt;
         fill_copy++;
      end else begin
         sum_copy -= ring_copy[oldest_copy];
         ring_copy[newest_copy] = rtt;
         oldest_copy = (newest_copy + 1) % WINDOW_DEPTH;
         if (newest_copy == 0) window_wraps++;
      end
      stats.gradient   = diff;
      stats.window_avg = sample_type'(sum_copy / longint'(fill_copy));
      stats.smoothed   = sample_type'(ema_copy);
      stats.held       = fill_copy[HELD_W-1:0];
      rtt_stats_expected.push_back(stats);
   endfunction

   task automatic add_sample(input logic signed [GRAD_W-1:0] value, input logic drain);
      sample_item_t item;
      item.rtt_sample  = value;
      item.drain_first = drain;
      sample_queue.push_back(item);
      samples_total++;
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.rtt_sample = '0;
      rsp_chan.ready      = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_rtt_sample(req_chan.rtt_sample);
            samples_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (sample_queue.size() > 0
                && !(sample_queue[0].drain_first
                     && (rtt_stats_expected.size() > 0 || req_chan.valid))
                && (calm_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_item = sample_queue.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.rtt_sample <= next_item.rtt_sample;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         monitor_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (rtt_stats_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected result item: gradient %0d average %0d smoothed %0d held %0d",
                           rsp_chan.rtt_gradient, rsp_chan.window_average,
                           rsp_chan.smoothed_average, rsp_chan.samples_held);
            end else begin
               want = rtt_stats_expected.pop_front();
               if (rsp_chan.rtt_gradient !== want.gradient
                   || rsp_chan.window_average !== want.window_avg
                   || rsp_chan.smoothed_average !== want.smoothed
                   || rsp_chan.samples_held !== want.held) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch on result %0d:", results_checked);
                     $display("  gradient exp %0d got %0d, average exp %0d got %0d",
                              want.gradient, rsp_chan.rtt_gradient,
                              want.window_avg, rsp_chan.window_average);
                     $display("  smoothed exp %0d got %0d, held exp %0d got %0d",
                              want.smoothed, rsp_chan.smoothed_average,
                              want.held, rsp_chan.samples_held);
                  end
               end
            end
         end
         if (monitor_cycles == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= calm_window() || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   initial begin
      int       positives;
      int       added;
      int       pick;
      bit [31:0] noise;
      logic signed [GRAD_W-1:0] value;

      clear_window_copy();

      add_sample('0, 1'b0);
      add_sample(-25'sd1, 1'b0);
      add_sample(-25'sd16777216, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd1, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd1, 1'b0);
      add_sample(25'h0555555, 1'b0);
      add_sample(25'h0AAAAAA, 1'b0);
      add_sample(25'h0800000, 1'b0);
      add_sample(-25'sd5, 1'b0);
      add_sample(25'h07FFFFF, 1'b0);
      add_sample(25'sd2, 1'b0);
      add_sample(25'h0FFFFFE, 1'b0);
      add_sample(25'sd100000, 1'b0);
      add_sample(25'sd100001, 1'b0);
      add_sample(25'sd99999, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd16777215, 1'b0);
      add_sample(25'sd3, 1'b0);

      positives = 0;
      added     = 0;
      while (positives < RANDOM_SAMPLES) begin
         pick  = $urandom_range(99);
         noise = $urandom;
         if (pick < 8) begin
            case ($urandom_range(2))
               0: value = '0;
               1: value = -25'sd1;
               default: value = {1'b1, noise[SAMPLE_W-1:0]};
            endcase
         end else begin
            if (pick < 50)
               value = {1'b0, sample_type'($urandom_range(24'hFFFFFF, 1))};
            else if (pick < 80)
               value = {1'b0, sample_type'($urandom_range(2000, 1))};
            else
               value = {1'b0, sample_type'($urandom_range(50500, 49500))};
            positives++;
         end
         add_sample(value, added == 0 || added == 400);
         added++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (samples_sent < samples_total) @(posedge clock);
      while (rtt_stats_expected.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d samples, %0d of them dropped as zero or negative.",
               samples_sent, samples_dropped);
      $display("Checked %0d result items; the window wrapped %0d times.",
               results_checked, window_wraps);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
